>>> rtl/core/tis_pkg.sv
package tis_pkg;

	localparam int TOOL_POSITIONS = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_UNLOCK_SEARCH_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERDRIVE_STEP_COUNT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCK_SETTLE_TICKS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNLOCK_PAUSE_TICKS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX_PAUSE_TICKS = 3'd4;

	localparam logic [15:0] RST_UNLOCK_SEARCH_LIMIT = 16'd1000;
	localparam logic [15:0] RST_OVERDRIVE_STEP_COUNT = 16'd3000;
	localparam logic [15:0] RST_LOCK_SETTLE_TICKS = 16'd50;
	localparam logic [15:0] RST_UNLOCK_PAUSE_TICKS = 16'd1000;
	localparam logic [15:0] RST_INDEX_PAUSE_TICKS = 16'd500;

	localparam logic [3:0] TARGET_MIN = 4'd1;
	localparam logic [3:0] TARGET_MAX = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE         = 4'd0,
		PH_SEARCH_FWD   = 4'd1,
		PH_SEARCH_BKD   = 4'd2,
		PH_UNLOCK_CONT  = 4'd3,
		PH_UNLOCK_PAUSE = 4'd4,
		PH_MOVE         = 4'd5,
		PH_LOCK_SETTLE  = 4'd6,
		PH_SEEK_INDEX   = 4'd7,
		PH_INDEX_PAUSE  = 4'd8,
		PH_REVERSE      = 4'd9,
		PH_OVERDRIVE    = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BKD  = 2'd2
	} unlock_dir_t;

	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_FWD = 2'd1;
	localparam logic [1:0] STEP_BKD = 2'd2;

	typedef struct packed {
		logic       command;
		logic [3:0] target_position;
		logic [3:0] position_code;
		logic       position_parity;
		logic       lock_switch;
		logic       index_switch;
	} tis_in_t;

	typedef struct packed {
		logic [1:0] step_pulse;
		logic       lock_coil;
		logic       busy_res;
		logic       done_res;
		logic       rejected;
		logic [3:0] decoded_position;
	} tis_out_t;

	// backward bit per {target, position}: shorter way round is backward
	function automatic logic [255:0] build_backward_table();
		logic [255:0] tbl;
		int d;
		tbl = '0;
		for (int t = 0; t < 16; t++) begin
			for (int p = 0; p < 16; p++) begin
				d = (t + 16 * TOOL_POSITIONS - p) % TOOL_POSITIONS;
				if (d == 0) begin
					d = TOOL_POSITIONS;
				end
				tbl[t * 16 + p] = (d > TOOL_POSITIONS / 2);
			end
		end
		return tbl;
	endfunction

	localparam logic [255:0] BACKWARD_TABLE = build_backward_table();

	function automatic logic [3:0] decode_position(logic [3:0] code, logic parity);
		logic [3:0] pos;
		pos = 4'd0;
		case (code) inside
			4'd1, 4'd2, 4'd4, 4'd7, 4'd8: pos = parity ? code : 4'd0;
			4'd3, 4'd5, 4'd6:             pos = parity ? 4'd0 : code;
			default:                      pos = 4'd0;
		endcase
		return pos;
	endfunction

endpackage

>>> rtl/core/turret_index_sequencer.sv
// Turret goto sequencer: one sensor tick per request, one result per request.
// The result of an accepted request is held in the output register from the next cycle.
// Throughput: one request per cycle while the output is not stalled; the sequencer state advances at each accept.
// The output register frees in the cycle it is taken, so input and output overlap.
// Reset (arst_n low): phase idle, coil off, counters clear, registers at defaults.
module turret_index_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tis_pkg::tis_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tis_pkg::tis_out_t              out_data,
	input  logic                           cfg_write_en,
	input  logic [tis_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tis_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tis_pkg::*;

	logic [15:0] search_limit_q;
	logic [15:0] overdrive_count_q;
	logic [15:0] settle_ticks_q;
	logic [15:0] unlock_pause_q;
	logic [15:0] index_pause_q;

	phase_t      phase_q, phase_d;
	logic        backward_q, backward_d;
	unlock_dir_t unlock_dir_q, unlock_dir_d;
	logic [3:0]  goal_q, goal_d;
	logic [15:0] count_q, count_d;
	logic        coil_q, coil_d;

	logic        out_valid_q;
	tis_out_t    out_data_q;
	tis_out_t    result;

	logic        accept;
	logic [3:0]  pos;
	logic [1:0]  travel_step;
	logic [1:0]  counter_step;
	logic        target_ok;

	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign pos = decode_position(in_data.position_code, in_data.position_parity);
	assign travel_step = backward_q ? STEP_BKD : STEP_FWD;
	assign counter_step = backward_q ? STEP_FWD : STEP_BKD;
	assign target_ok = (in_data.target_position >= TARGET_MIN) &&
		(in_data.target_position <= TARGET_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_limit_q <= RST_UNLOCK_SEARCH_LIMIT;
			overdrive_count_q <= RST_OVERDRIVE_STEP_COUNT;
			settle_ticks_q <= RST_LOCK_SETTLE_TICKS;
			unlock_pause_q <= RST_UNLOCK_PAUSE_TICKS;
			index_pause_q <= RST_INDEX_PAUSE_TICKS;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_UNLOCK_SEARCH_LIMIT:  search_limit_q <= cfg_data;
				REG_OVERDRIVE_STEP_COUNT: overdrive_count_q <= cfg_data;
				REG_LOCK_SETTLE_TICKS:    settle_ticks_q <= cfg_data;
				REG_UNLOCK_PAUSE_TICKS:   unlock_pause_q <= cfg_data;
				REG_INDEX_PAUSE_TICKS:    index_pause_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		backward_d = backward_q;
		unlock_dir_d = unlock_dir_q;
		goal_d = goal_q;
		count_d = count_q;
		coil_d = coil_q;
		result.step_pulse = STEP_NONE;
		result.done_res = 1'b0;
		result.rejected = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (in_data.command) begin
					if (!target_ok) begin
						result.rejected = 1'b1;
					end else if (in_data.target_position == pos) begin
						result.done_res = 1'b1;
					end else begin
						backward_d = BACKWARD_TABLE[{in_data.target_position, pos}];
						goal_d = in_data.target_position;
						unlock_dir_d = DIR_NONE;
						coil_d = 1'b0;
						count_d = '0;
						phase_d = PH_SEARCH_FWD;
					end
				end
			end
			PH_SEARCH_FWD, PH_SEARCH_BKD: begin
				if (!in_data.lock_switch) begin
					unlock_dir_d = (phase_q == PH_SEARCH_FWD) ? DIR_FWD : DIR_BKD;
					count_d = '0;
					phase_d = PH_UNLOCK_PAUSE;
				end else if (count_q < search_limit_q) begin
					result.step_pulse = (phase_q == PH_SEARCH_FWD) ? STEP_FWD : STEP_BKD;
					count_d = count_q + 16'd1;
				end else begin
					count_d = '0;
					phase_d = (phase_q == PH_SEARCH_FWD) ? PH_SEARCH_BKD : PH_UNLOCK_CONT;
				end
			end
			PH_UNLOCK_CONT: begin
				if (in_data.lock_switch) begin
					result.step_pulse = (unlock_dir_q == DIR_FWD) ? STEP_FWD : STEP_BKD;
				end else begin
					count_d = '0;
					phase_d = PH_UNLOCK_PAUSE;
				end
			end
			PH_UNLOCK_PAUSE: begin
				if (count_q < unlock_pause_q) begin
					count_d = count_q + 16'd1;
				end else begin
					count_d = '0;
					phase_d = PH_MOVE;
				end
			end
			PH_MOVE: begin
				if (pos == goal_q) begin
					coil_d = 1'b1;
					count_d = '0;
					phase_d = PH_LOCK_SETTLE;
				end else begin
					result.step_pulse = travel_step;
				end
			end
			PH_LOCK_SETTLE: begin
				if (count_q < settle_ticks_q) begin
					count_d = count_q + 16'd1;
				end else begin
					count_d = '0;
					phase_d = PH_SEEK_INDEX;
				end
			end
			PH_SEEK_INDEX: begin
				if (in_data.index_switch) begin
					count_d = '0;
					phase_d = PH_INDEX_PAUSE;
				end else begin
					result.step_pulse = travel_step;
				end
			end
			PH_INDEX_PAUSE: begin
				if (count_q < index_pause_q) begin
					count_d = count_q + 16'd1;
				end else begin
					count_d = '0;
					phase_d = PH_REVERSE;
				end
			end
			PH_REVERSE: begin
				if (in_data.lock_switch) begin
					count_d = '0;
					phase_d = PH_OVERDRIVE;
				end else begin
					result.step_pulse = counter_step;
				end
			end
			PH_OVERDRIVE: begin
				if (count_q < overdrive_count_q) begin
					result.step_pulse = counter_step;
					count_d = count_q + 16'd1;
				end else begin
					coil_d = 1'b0;
					count_d = '0;
					phase_d = PH_IDLE;
					result.done_res = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				count_d = '0;
			end
		endcase
		result.lock_coil = coil_d;
		result.busy_res = (phase_d != PH_IDLE);
		result.decoded_position = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			backward_q <= 1'b0;
			goal_q <= '0;
			count_q <= '0;
			coil_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			backward_q <= backward_d;
			goal_q <= goal_d;
			count_q <= count_d;
			coil_q <= coil_d;
		end
	end

	// direction found by the search; always set before it is read
	always_ff @(posedge clk) begin
		if (accept) begin
			unlock_dir_q <= unlock_dir_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

endmodule
